>>> sv/hgcu_pkg.sv
`timescale 1ns / 1ps
package hgcu_pkg;

  localparam int GRID_DIM_DEF = 64;
  localparam int TEX_DIM_DEF  = 512;
  localparam int QDEPTH       = 4;

  localparam logic [16:0] ONE      = 17'd65536;
  localparam logic [22:0] M_DIV3   = 23'd5592406;
  localparam logic [30:0] M_HUE    = 31'd2126008812;
  localparam logic [23:0] M_DIV100 = 24'd10737419;
  localparam logic [22:0] V_BASE   = 23'd2949120;
  localparam logic [22:0] V_GAIN   = 23'd25;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [2:0] {
    REG_GRID_ROWS = 3'd0,
    REG_GRID_COLS = 3'd1,
    REG_TEX_ROWS  = 3'd2,
    REG_TEX_COLS  = 3'd3,
    REG_ROW_STEP  = 3'd4,
    REG_COL_STEP  = 3'd5,
    REG_CHANNELS  = 3'd6
  } reg_idx_e;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  typedef struct packed {
    logic [6:0]  grid_rows;
    logic [6:0]  grid_cols;
    logic [9:0]  tex_rows;
    logic [9:0]  tex_cols;
    logic [21:0] row_step;
    logic [21:0] col_step;
    logic [2:0]  channels;
  } cfg_t;

  typedef struct packed {
    logic [8:0] out_row;
    logic [8:0] out_col;
    logic [7:0] alpha;
  } tag_t;

  typedef struct packed {
    kind_e              kind;
    logic [5:0]         grid_row;
    logic [5:0]         grid_col;
    logic signed [15:0] height;
    logic [30:0]        ypos;
    logic [30:0]        xpos;
    tag_t               tag;
  } item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_ctl_t;

endpackage

>>> sv/hgcu_ram.sv
`timescale 1ns / 1ps
module hgcu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/hgcu_fifo.sv
`timescale 1ns / 1ps
module hgcu_fifo
  import hgcu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wdata,
  input  logic  pop,
  output item_t rdata,
  output logic  full,
  output logic  empty
);

  localparam int QAW = $clog2(QDEPTH);

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QAW:0]   count;

  assign full  = (count == (QAW + 1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      count <= count + (QAW + 1)'(push) - (QAW + 1)'(pop);
    end
  end

endmodule

>>> sv/hgcu_front.sv
`timescale 1ns / 1ps
module hgcu_front
  import hgcu_pkg::*;
#(
  parameter int TEX_DIM = TEX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        q_full,
  output logic        q_push,
  output item_t       item
);

  logic       fv;
  item_t      item_next;
  logic [8:0] tex_row;
  logic [8:0] tex_col;
  logic [31:0] trows;

  assign tex_row  = s_tdata[36:28];
  assign tex_col  = s_tdata[45:37];
  assign s_tready = !fv || !q_full;
  assign q_push   = fv && !q_full;

  always_comb begin
    trows = 32'(cfg.tex_rows);
    if (trows < 32'd2) begin
      trows = 32'd2;
    end else if (trows > 32'(TEX_DIM)) begin
      trows = 32'(TEX_DIM);
    end
    item_next.kind          = kind_e'(s_tuser[0]);
    item_next.grid_row      = s_tdata[5:0];
    item_next.grid_col      = s_tdata[11:6];
    item_next.height        = s_tdata[27:12];
    item_next.ypos          = 31'(tex_row) * 31'(cfg.row_step);
    item_next.xpos          = 31'(tex_col) * 31'(cfg.col_step);
    item_next.tag.out_row   = 9'(trows - 32'd1 - 32'(tex_row));
    item_next.tag.out_col   = tex_col;
    item_next.tag.alpha     = (cfg.channels == 3'd4) ? ALPHA_OPAQUE : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tready) begin
      fv <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= item_next;
    end
  end

endmodule

>>> sv/hgcu_back.sv
`timescale 1ns / 1ps
module hgcu_back
  import hgcu_pkg::*;
#(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  item_t       item,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata
);

  localparam int RB    = $clog2(GRID_DIM);
  localparam int HALF  = (GRID_DIM + 1) / 2;
  localparam int BDEP  = HALF * HALF;
  localparam int AW    = (BDEP > 1) ? $clog2(BDEP) : 1;

  logic adv;
  assign adv   = !m_tvalid || m_tready;
  assign q_pop = adv && !q_empty;

  // stage 1: base cell and fraction
  logic [31:0] nr, nc, lim_r, lim_c, by, bx, fr_r, fr_c;
  logic        v1;
  item_t       i1;
  logic [RB-1:0] r0_1, c0_1;
  logic [16:0] fy1, fx1;

  always_comb begin
    nr = 32'(cfg.grid_rows);
    if (nr < 32'd2) nr = 32'd2;
    else if (nr > 32'(GRID_DIM)) nr = 32'(GRID_DIM);
    nc = 32'(cfg.grid_cols);
    if (nc < 32'd2) nc = 32'd2;
    else if (nc > 32'(GRID_DIM)) nc = 32'(GRID_DIM);
    lim_r = nr - 32'd2;
    lim_c = nc - 32'd2;
    by = 32'(item.ypos[30:16]);
    bx = 32'(item.xpos[30:16]);
    fr_r = 32'(item.ypos[15:0]);
    fr_c = 32'(item.xpos[15:0]);
    if (by > lim_r) begin
      fr_r = 32'(item.ypos) - (lim_r << 16);
      by   = lim_r;
    end
    if (bx > lim_c) begin
      fr_c = 32'(item.xpos) - (lim_c << 16);
      bx   = lim_c;
    end
    if (fr_r > 32'(ONE)) fr_r = 32'(ONE);
    if (fr_c > 32'(ONE)) fr_c = 32'(ONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i1   <= item;
      r0_1 <= RB'(by);
      c0_1 <= RB'(bx);
      fy1  <= 17'(fr_r);
      fx1  <= 17'(fr_c);
    end
  end

  // stage 2: bank addresses, height writes, bank reads
  logic [AW-1:0] raddr [4];
  logic [15:0]   rdata [4];
  logic [3:0]    wsel;
  logic [AW-1:0] waddr;
  logic          in_grid;
  logic          v2;
  logic          rp2, cp2;
  logic [16:0]   fy2, fx2;
  tag_t          tag2;

  always_comb begin
    in_grid = (32'(i1.grid_row) < 32'(GRID_DIM)) && (32'(i1.grid_col) < 32'(GRID_DIM));
    waddr = AW'(32'(i1.grid_row >> 1) * 32'(HALF) + 32'(i1.grid_col >> 1));
    wsel = '0;
    if (adv && v1 && i1.kind == KIND_LOAD && in_grid) begin
      wsel[{i1.grid_row[0], i1.grid_col[0]}] = 1'b1;
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic ROW_PAR = 1'((b >> 1) & 1);
    localparam logic COL_PAR = 1'(b & 1);
    logic [RB:0] rr, cc;
    always_comb begin
      rr = (r0_1[0] == ROW_PAR) ? {1'b0, r0_1} : {1'b0, r0_1} + 1'b1;
      cc = (c0_1[0] == COL_PAR) ? {1'b0, c0_1} : {1'b0, c0_1} + 1'b1;
      raddr[b] = AW'(32'(rr >> 1) * 32'(HALF) + 32'(cc >> 1));
    end
    hgcu_ram #(.WIDTH(16), .DEPTH(BDEP)) u_ram (
      .clk   (clk),
      .we    (wsel[b]),
      .waddr (waddr),
      .wdata (i1.height),
      .re    (adv),
      .raddr (raddr[b]),
      .rdata (rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1 && i1.kind == KIND_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rp2  <= r0_1[0];
      cp2  <= c0_1[0];
      fy2  <= fy1;
      fx2  <= fx1;
      tag2 <= i1.tag;
    end
  end

  // stage 3: blend along columns
  logic signed [15:0] h00, h01, h10, h11;
  logic signed [33:0] a0, a1;
  logic        v3;
  logic [16:0] fy3;
  tag_t        tag3;

  always_comb begin
    h00 = rdata[{rp2, cp2}];
    h01 = rdata[{rp2, !cp2}];
    h10 = rdata[{!rp2, cp2}];
    h11 = rdata[{!rp2, !cp2}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0 <= h00 * $signed({1'b0, 17'(ONE - fx2)}) + h01 * $signed({1'b0, fx2});
      a1 <= h10 * $signed({1'b0, 17'(ONE - fx2)}) + h11 * $signed({1'b0, fx2});
      fy3  <= fy2;
      tag3 <= tag2;
    end
  end

  // stage 4: blend along rows
  logic signed [49:0] z4;
  logic        v4;
  tag_t        tag4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z4 <= a0 * $signed({1'b0, 17'(ONE - fy3)}) + a1 * $signed({1'b0, fy3});
      tag4 <= tag3;
    end
  end

  // stage 5: magnitude
  logic [48:0] mag;
  logic        v5, neg5;
  logic [21:0] w5;
  tag_t        tag5;

  assign mag = z4[49] ? 49'(-z4) : 49'(z4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg5 <= z4[49];
      w5   <= 22'(mag >> 26);
      tag5 <= tag4;
    end
  end

  // stage 6: divide by three, saturate
  logic [45:0] p3;
  logic [21:0] q0;
  logic        v6, neg6;
  logic [16:0] q6;
  tag_t        tag6;

  assign p3 = 46'(w5) * 46'(M_DIV3);
  assign q0 = p3[45:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg6 <= neg5;
      q6   <= (q0 > 22'(ONE)) ? ONE : 17'(q0);
      tag6 <= tag5;
    end
  end

  // stage 7: hue and value
  logic [17:0] n7;
  logic [49:0] ph;
  logic [22:0] num;
  logic [46:0] pv;
  logic        v7;
  logic [18:0] h6_7;
  logic [15:0] val7;
  tag_t        tag7;

  assign n7  = neg6 ? 18'(ONE) + 18'(q6) : 18'(ONE) - 18'(q6);
  assign ph  = 50'(n7) * 50'(M_HUE);
  assign num = V_BASE + 23'(q6) * V_GAIN;
  assign pv  = 47'(num) * 47'(M_DIV100);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h6_7 <= 19'(ph >> 30);
      val7 <= 16'(pv >> 30);
      tag7 <= tag6;
    end
  end

  // stage 8: sector, ramp, chroma
  logic [2:0]  sec3;
  logic [16:0] t8;
  logic        v8;
  logic [2:0]  sec8;
  logic [16:0] f8;
  logic [15:0] c8, val8;
  tag_t        tag8;

  assign sec3 = h6_7[18:16];
  assign t8   = h6_7[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sec8 <= (sec3 >= 3'd6) ? sec3 - 3'd6 : sec3;
      f8   <= t8[16] ? 17'(18'h20000 - 18'(t8)) : t8;
      c8   <= 16'((32'(val7) * 32'(val7)) >> 16);
      val8 <= val7;
      tag8 <= tag7;
    end
  end

  // stage 9: sector colors
  logic [15:0] x9;
  logic [15:0] cr, cg, cb;
  logic        v9;
  logic [15:0] r9, g9, b9, m9;
  tag_t        tag9;

  assign x9 = 16'((33'(c8) * 33'(f8)) >> 16);

  always_comb begin
    unique case (sec8)
      3'd0: begin cr = c8;    cg = x9;    cb = 16'd0; end
      3'd1: begin cr = x9;    cg = c8;    cb = 16'd0; end
      3'd2: begin cr = 16'd0; cg = c8;    cb = x9;    end
      3'd3: begin cr = 16'd0; cg = x9;    cb = c8;    end
      3'd4: begin cr = x9;    cg = 16'd0; cb = c8;    end
      default: begin cr = c8; cg = 16'd0; cb = x9;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r9   <= cr;
      g9   <= cg;
      b9   <= cb;
      m9   <= val8 - c8;
      tag9 <= tag8;
    end
  end

  // output register
  function automatic logic [7:0] to_byte(input logic [15:0] col, input logic [15:0] m);
    logic [24:0] p;
    p = (25'(col) + 25'(m)) * 25'd255;
    return p[23:16];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {6'd0, tag9.out_col, tag9.out_row, tag9.alpha,
                  to_byte(b9, m9), to_byte(g9, m9), to_byte(r9, m9)};
    end
  end

endmodule

>>> sv/height_grid_color_upscale.sv
`timescale 1ns / 1ps
// Height grid color upscaler.
// s_* carries items in: s_tuser is the kind (0 load a height, 1 request a pixel).
// Loads write one height into the grid and give no result; a pixel request
// gives one RGBA result on m_* with its flipped row and its column.
// cfg_* writes one configuration register per handshake; write only while idle.
// Throughput is one item per cycle while the output is not stalled; from s_* acceptance
// to m_tvalid an item passes the input register, the item queue, nine pixel stages
// and the output register, in that order.
// The grid sits in four row/column parity
// banks, so each of the four neighbor heights comes from its own read port.
// Reset restores the register defaults and empties the pipeline; heights are
// undefined until loaded. When m_tvalid is high and m_tready is low the whole back pipeline holds,
// the queue fills, and s_tready drops once the queue and input register are full.
module height_grid_color_upscale
  import hgcu_pkg::*;
#(
  parameter int GRID_DIM = GRID_DIM_DEF,
  parameter int TEX_DIM  = TEX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // grid_row, grid_col, height, tex_row, tex_col
  input  logic [0:0]  s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // red, green, blue, alpha, out_row, out_col
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data
);

  cfg_t   cfg;
  item_t  q_in, q_out;
  q_ctl_t q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_rows <= 7'd64;
      cfg.grid_cols <= 7'd64;
      cfg.tex_rows  <= 10'd512;
      cfg.tex_cols  <= 10'd512;
      cfg.row_step  <= 22'd8079;
      cfg.col_step  <= 22'd8079;
      cfg.channels  <= 3'd3;
    end else if (cfg_valid) begin
      unique case (reg_idx_e'(cfg_index))
        REG_GRID_ROWS: cfg.grid_rows <= cfg_data[6:0];
        REG_GRID_COLS: cfg.grid_cols <= cfg_data[6:0];
        REG_TEX_ROWS:  cfg.tex_rows  <= cfg_data[9:0];
        REG_TEX_COLS:  cfg.tex_cols  <= cfg_data[9:0];
        REG_ROW_STEP:  cfg.row_step  <= cfg_data;
        REG_COL_STEP:  cfg.col_step  <= cfg_data;
        REG_CHANNELS:  cfg.channels  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  hgcu_front #(.TEX_DIM(TEX_DIM)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q.full),
    .q_push   (q.push),
    .item     (q_in)
  );

  hgcu_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q.push),
    .wdata (q_in),
    .pop   (q.pop),
    .rdata (q_out),
    .full  (q.full),
    .empty (q.empty)
  );

  hgcu_back #(.GRID_DIM(GRID_DIM)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .item     (q_out),
    .q_empty  (q.empty),
    .q_pop    (q.pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_alpha_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:24] == 8'd0 || m_tdata[31:24] == 8'hFF))
    else $error("alpha neither 0 nor 255");

  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !q.pop)
    else $error("queue popped while output stalled");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (q.full && !q.pop) |=> q.full)
    else $error("full queue lost an item");

endmodule

>>> tb/hgcu_checker.sv
`timescale 1ns / 1ps
module hgcu_checker
  import hgcu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          pixels_seen
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [8:0] row;
    logic [8:0] col;
  } pixel_t;

  localparam longint UNIT = 65536;

  logic [6:0]  grid_rows, grid_cols;
  logic [9:0]  tex_rows, tex_cols;
  logic [21:0] row_step, col_step;
  logic [2:0]  channels;
  shortint     heights [4096];
  pixel_t      pixel_q [$];

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void axis(longint pos, longint step, longint n,
                               output longint base, output longint frac);
    longint y;
    y = pos * step;
    base = y >>> 16;
    if (base > n - 2) base = n - 2;
    frac = y - (base <<< 16);
    if (frac > UNIT) frac = UNIT;
  endfunction

  function automatic longint hgt(longint r, longint c);
    return longint'(heights[r * 64 + c]);
  endfunction

  function automatic pixel_t shade(logic [8:0] trow, logic [8:0] tcol);
    pixel_t p;
    longint nr, nc, nt, r0, c0, fy, fx, z, mag, q, s, h6, t, f, v, c, x, m;
    longint rgb [3];
    int sector;
    nr = clamp(grid_rows, 2, 64);
    nc = clamp(grid_cols, 2, 64);
    nt = clamp(tex_rows, 2, 512);
    axis(trow, row_step, nr, r0, fy);
    axis(tcol, col_step, nc, c0, fx);
    z = hgt(r0, c0) * ((UNIT - fy) * (UNIT - fx)) + hgt(r0, c0 + 1) * ((UNIT - fy) * fx)
      + hgt(r0 + 1, c0) * (fy * (UNIT - fx)) + hgt(r0 + 1, c0 + 1) * (fy * fx);
    mag = z < 0 ? -z : z;
    q = (mag * 4) / (longint'(3) <<< 28);
    if (q > UNIT) q = UNIT;
    s = z < 0 ? -q : q;
    h6 = (UNIT - s) * 198 / 100;
    sector = int'((h6 >>> 16) % 6);
    t = h6 & 'h1FFFF;
    f = UNIT - (t >= UNIT ? t - UNIT : UNIT - t);
    v = (45 * UNIT + 25 * q) / 100;
    c = (v * v) >>> 16;
    x = (c * f) >>> 16;
    m = v - c;
    case (sector)
      0: rgb = '{c, x, 0};
      1: rgb = '{x, c, 0};
      2: rgb = '{0, c, x};
      3: rgb = '{0, x, c};
      4: rgb = '{x, 0, c};
      default: rgb = '{c, 0, x};
    endcase
    p.red   = 8'(((rgb[0] + m) * 255) >>> 16);
    p.green = 8'(((rgb[1] + m) * 255) >>> 16);
    p.blue  = 8'(((rgb[2] + m) * 255) >>> 16);
    p.alpha = channels == 3'd4 ? ALPHA_OPAQUE : 8'd0;
    p.row   = 9'(nt - 1 - trow);
    p.col   = tcol;
    return p;
  endfunction

  always @(posedge clk) begin
    pixel_t got, want;
    if (rst) begin
      grid_rows <= 7'd64;
      grid_cols <= 7'd64;
      tex_rows  <= 10'd512;
      tex_cols  <= 10'd512;
      row_step  <= 22'd8079;
      col_step  <= 22'd8079;
      channels  <= 3'd3;
      pixel_q.delete();
      errors <= 0;
      pending <= 0;
      pixels_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_e'(cfg_index))
          REG_GRID_ROWS: grid_rows <= cfg_data[6:0];
          REG_GRID_COLS: grid_cols <= cfg_data[6:0];
          REG_TEX_ROWS:  tex_rows  <= cfg_data[9:0];
          REG_TEX_COLS:  tex_cols  <= cfg_data[9:0];
          REG_ROW_STEP:  row_step  <= cfg_data;
          REG_COL_STEP:  col_step  <= cfg_data;
          REG_CHANNELS:  channels  <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.red   = m_tdata[7:0];
        got.green = m_tdata[15:8];
        got.blue  = m_tdata[23:16];
        got.alpha = m_tdata[31:24];
        got.row   = m_tdata[40:32];
        got.col   = m_tdata[49:41];
        pixels_seen <= pixels_seen + 1;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel r%0d g%0d b%0d a%0d row %0d col %0d", $time,
                   got.red, got.green, got.blue, got.alpha, got.row, got.col);
          errors <= errors + 1;
        end else begin
          want = pixel_q.pop_front();
          if (got != want) begin
            $display("%0t: expected r%0d g%0d b%0d a%0d row %0d col %0d", $time,
                     want.red, want.green, want.blue, want.alpha, want.row, want.col);
            $display("%0t: actual   r%0d g%0d b%0d a%0d row %0d col %0d", $time,
                     got.red, got.green, got.blue, got.alpha, got.row, got.col);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (kind_e'(s_tuser[0]) == KIND_LOAD)
          heights[s_tdata[5:0] * 64 + s_tdata[11:6]] = shortint'(s_tdata[27:12]);
        else
          pixel_q.insert(pixel_q.size(), shade(s_tdata[36:28], s_tdata[45:37]));
      end
      pending <= pixel_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import hgcu_pkg::*;

  localparam int LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [21:0] cfg_data = '0;

  int errors, pending, pixels_seen;
  int cycles = 0;
  int tx_pct = 0;
  int rx_pct = 0;
  int sent = 0;
  bit written [4096];
  logic [6:0]  cur_rows = 7'd64, cur_cols = 7'd64;
  logic [21:0] cur_rstep = 22'd8079, cur_cstep = 22'd8079;

  height_grid_color_upscale DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  hgcu_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending, .pixels_seen
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    m_tready <= $urandom_range(99) >= rx_pct;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send(kind_e kind, logic [47:0] data);
    while ($urandom_range(99) < tx_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic load(int r, int c, logic [15:0] h);
    send(KIND_LOAD, {2'b0, 9'd0, 9'd0, h, 6'(c), 6'(r)});
    written[r * 64 + c] = 1'b1;
  endtask

  function automatic logic [15:0] rand_height();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int base_of(int pos, logic [21:0] step, logic [6:0] n);
    longint b, lim;
    lim = n < 2 ? 0 : (n > 64 ? 62 : n - 2);
    b = (longint'(pos) * step) >>> 16;
    return int'(b > lim ? lim : b);
  endfunction

  // fill any unloaded neighbor cells before the request
  task automatic pixel(int tr, int tc);
    int r0, c0;
    r0 = base_of(tr, cur_rstep, cur_rows);
    c0 = base_of(tc, cur_cstep, cur_cols);
    for (int dr = 0; dr < 2; dr++)
      for (int dc = 0; dc < 2; dc++)
        if (!written[(r0 + dr) * 64 + c0 + dc]) load(r0 + dr, c0 + dc, rand_height());
    send(KIND_PIXEL, {2'b0, 9'(tc), 9'(tr), 16'd0, 12'd0});
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_e idx, logic [21:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRID_ROWS: cur_rows  = val[6:0];
      REG_GRID_COLS: cur_cols  = val[6:0];
      REG_ROW_STEP:  cur_rstep = val;
      REG_COL_STEP:  cur_cstep = val;
      default: ;
    endcase
  endtask

  task automatic configure(int gr, int gc, int trs, int tcs, int rs, int cs, int ch);
    drain();
    cfg_write(REG_GRID_ROWS, 22'(gr));
    cfg_write(REG_GRID_COLS, 22'(gc));
    cfg_write(REG_TEX_ROWS, 22'(trs));
    cfg_write(REG_TEX_COLS, 22'(tcs));
    cfg_write(REG_ROW_STEP, 22'(rs));
    cfg_write(REG_COL_STEP, 22'(cs));
    cfg_write(REG_CHANNELS, 22'(ch));
  endtask

  initial begin
    int gr, gc, trs, tcs, rs, cs, goal;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, extreme heights, first and last pixel
    load(0, 0, 16'h7FFF);
    load(0, 1, 16'h8000);
    load(1, 0, 16'h0000);
    load(1, 1, 16'h7FFF);
    pixel(0, 0);
    pixel(1, 3);
    pixel(511, 511);

    // smallest grid and texture, fraction saturating past the last cell
    configure(2, 2, 2, 2, 65536, 65536, 4);
    for (int i = 0; i < 4; i++) load(i / 2, i % 2, 16'h7FFF);
    pixel(0, 0);
    pixel(1, 1);
    pixel(7, 300);
    for (int i = 0; i < 4; i++) load(i / 2, i % 2, 16'h8000);
    pixel(0, 1);
    pixel(1, 0);

    // sizes out of range, largest steps, odd channel count
    configure(0, 127, 1023, 0, 4194303, 4194303, 7);
    pixel(511, 511);
    pixel(0, 0);
    pixel(3, 2);
    configure(64, 64, 0, 512, 0, 0, 0);
    pixel(100, 200);

    goal = sent + 1250;
    for (int ph = 0; sent < goal; ph++) begin
      gr  = $urandom_range(9) == 0 ? $urandom_range(127) : $urandom_range(2, 64);
      gc  = $urandom_range(9) == 0 ? $urandom_range(127) : $urandom_range(2, 64);
      trs = $urandom_range(9) == 0 ? $urandom_range(1023) : $urandom_range(2, 512);
      tcs = $urandom_range(2, 512);
      rs  = $urandom_range(3) == 0 ? $urandom_range(22'h3FFFFF)
                                   : ((gr - 1) * 65536) / (trs < 2 ? 1 : trs - 1);
      cs  = $urandom_range(3) == 0 ? $urandom_range(22'h3FFFFF)
                                   : ((gc - 1) * 65536) / (tcs < 2 ? 1 : tcs - 1);
      configure(gr, gc, trs, tcs, rs, cs, $urandom_range(7));
      for (int i = 0; i < 250 && sent < goal; i++) begin
        case ((i / 40) % 5)
          0: begin tx_pct = 0;  rx_pct = 0;  end
          1: begin tx_pct = 65; rx_pct = 0;  end
          2: begin tx_pct = 0;  rx_pct = 65; end
          3: begin tx_pct = 9;  rx_pct = 9;  end
          default: begin tx_pct = 0; rx_pct = 0; end
        endcase
        if (i == 125) drain();
        if ($urandom_range(4) == 0)
          load($urandom_range(63), $urandom_range(63), rand_height());
        else
          pixel($urandom_range(511), $urandom_range(511));
      end
    end

    tx_pct = 0;
    rx_pct = 0;
    drain();
    $display("Sent %0d items, %0d pixels checked, across several grid and texture settings",
             sent, pixels_seen);
    $display("Covered load and pixel items, clamped sizes, saturated fractions and stalls");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
